[src/mstrc_pkg.sv]
// Package for the minimum spanning tree unit with per-city root costs.
// Holds the item structs, the internal record types and the sequencer states.
// Depends on nothing.
`timescale 1ns / 1ps

package mstrc_pkg;

	localparam int COORD_W = 20;
	localparam int COST_W  = 30;
	localparam int RATE_W  = 30;
	localparam int DIST_W  = COORD_W + 1;
	localparam int RSUM_W  = RATE_W + 1;
	localparam int EDGE_W  = 52;
	localparam int TOTAL_W = 57;
	localparam int OIDX_W  = 6;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef struct packed {
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [COST_W-1:0]  station_cost;
		logic [RATE_W-1:0]  wire_rate;
		logic               last_city;
	} city_item_t;

	typedef struct packed {
		logic               is_station;
		logic [OIDX_W-1:0]  parent_city;
		logic [OIDX_W-1:0]  city_index;
		logic [EDGE_W-1:0]  edge_cost;
		logic [TOTAL_W-1:0] running_total;
		logic               last_result;
		logic               overflow;
	} link_item_t;

	// One stored city.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COST_W-1:0]  sc;
		logic [RATE_W-1:0]  rate;
	} city_rec_t;

	// Best known connection of an open city.
	typedef struct packed {
		logic [EDGE_W-1:0] cost;
		logic [OIDX_W-1:0] parent;
		logic              station;
	} best_rec_t;

	// One sweep element travelling through the cost unit.
	typedef struct packed {
		logic [OIDX_W-1:0] idx;
		logic [COST_W-1:0] sc;
		best_rec_t         best;
	} sweep_tag_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SWEEP,
		ST_EMIT,
		ST_PICK_RD,
		ST_PICK_LAT
	} state_t;

endpackage

[src/mstrc_cost_unit.sv]
// Shared wire cost unit: distance and rate sum, then one multiply.
// Two register stages; uses mstrc_pkg.
`timescale 1ns / 1ps

module mstrc_cost_unit
	import mstrc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  city_rec_t         pick,
	input  city_rec_t         other,
	input  sweep_tag_t        tag,
	output logic              res_valid,
	output sweep_tag_t        res_tag,
	output logic [EDGE_W-1:0] wire_cost,
	output logic              busy
);

	logic [COORD_W-1:0] dx, dy;
	logic               v_s2, v_s3;
	logic [DIST_W-1:0]  dist_s2;
	logic [RSUM_W-1:0]  rsum_s2;
	sweep_tag_t         tag_s2, tag_s3;
	logic [EDGE_W-1:0]  wire_s3;

	// Absolute coordinate differences.
	always_comb begin
		dx = (pick.x > other.x) ? pick.x - other.x : other.x - pick.x;
		dy = (pick.y > other.y) ? pick.y - other.y : other.y - pick.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= valid;
			v_s3 <= v_s2;
		end
	end

	// Distance and rate sum, then the full-width product.
	always_ff @(posedge clk) begin
		dist_s2 <= {1'b0, dx} + {1'b0, dy};
		rsum_s2 <= {1'b0, pick.rate} + {1'b0, other.rate};
		tag_s2  <= tag;
		wire_s3 <= EDGE_W'(rsum_s2) * EDGE_W'(dist_s2);
		tag_s3  <= tag_s2;
	end

	assign res_valid = v_s3;
	assign res_tag   = tag_s3;
	assign wire_cost = wire_s3;
	assign busy      = v_s2 | v_s3;

endmodule

[src/min_spanning_tree_with_root_costs_unit.sv]
// Top level of the minimum spanning tree unit with per-city root costs.
// Uses mstrc_pkg and mstrc_cost_unit.
`timescale 1ns / 1ps

// Cities are loaded one item per cycle; the item flagged last_city starts a
// dense Prim run over the n stored cities, where a virtual root reaches each
// city at its station cost. One result item is produced per city in order of
// connection. Each step is one sweep over all n cities through the shared
// cost unit (one memory read per cycle, then the read register and the two
// unit stages drain), followed by emitting the result and fetching the
// picked city; output stalls hold the run in the emit state. No items are
// taken during that run; items beyond MAX_CITIES are dropped and flagged.
module min_spanning_tree_with_root_costs_unit
	import mstrc_pkg::*;
#(
	parameter int MAX_CITIES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       city_valid,
	output logic       city_ready,
	input  city_item_t city,
	output logic       link_valid,
	input  logic       link_ready,
	output link_item_t link
);

	localparam int IDX_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int CNT_W = $clog2(MAX_CITIES + 1);

	state_t state_q, state_d;

	city_rec_t city_mem [MAX_CITIES];
	best_rec_t best_mem [MAX_CITIES];

	logic [CNT_W-1:0]      cnt_q, n_q, iss_q, step_q;
	logic                  ovf_q, init_q, found_q, rd_v_s1;
	logic [MAX_CITIES-1:0] conn_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [IDX_W-1:0]      min_idx_q, pick_idx_q, rd_idx_s1, rd_addr;
	best_rec_t             min_q, best_rd_s1, cand;
	city_rec_t             city_rd_s1, pick_q;
	link_item_t            out_q;
	logic                  out_v_q;

	logic                  accept, room, issue, can_out, sweep_done, last_step;
	logic                  res_valid, unit_busy, res_open;
	sweep_tag_t            res_tag;
	logic [EDGE_W-1:0]     unit_wire;
	logic [IDX_W-1:0]      res_idx;
	logic [TOTAL_W:0]      sum;

	assign accept     = city_valid && city_ready;
	assign room       = cnt_q < CNT_W'(MAX_CITIES);
	assign issue      = (state_q == ST_SWEEP) && (iss_q < n_q);
	assign sweep_done = (iss_q == n_q) && !rd_v_s1 && !unit_busy && !res_valid;
	assign can_out    = !out_v_q || link_ready;
	assign last_step  = (step_q + 1'b1) == n_q;
	assign rd_addr    = (state_q == ST_PICK_RD) ? min_idx_q : iss_q[IDX_W-1:0];
	assign sum        = {1'b0, total_q} + (TOTAL_W + 1)'(min_q.cost);
	assign res_idx    = res_tag.idx[IDX_W-1:0];
	assign res_open   = !conn_q[res_idx];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:     if (accept && city.last_city) state_d = ST_SWEEP;
			ST_SWEEP:    if (sweep_done) state_d = ST_EMIT;
			ST_EMIT:     if (can_out) state_d = last_step ? ST_LOAD : ST_PICK_RD;
			ST_PICK_RD:  state_d = ST_PICK_LAT;
			ST_PICK_LAT: state_d = ST_SWEEP;
			default:     state_d = ST_LOAD;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		city_ready = (state_q == ST_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// City and best-connection memories.
	always_ff @(posedge clk) begin
		if (accept && room)
			city_mem[cnt_q[IDX_W-1:0]] <= '{x: city.x_coord, y: city.y_coord,
				sc: city.station_cost, rate: city.wire_rate};
		city_rd_s1 <= city_mem[rd_addr];
		best_rd_s1 <= best_mem[rd_addr];
		rd_idx_s1  <= rd_addr;
		if (res_valid && res_open)
			best_mem[res_idx] <= cand;
	end

	mstrc_cost_unit u_cost (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (rd_v_s1),
		.pick      (pick_q),
		.other     (city_rd_s1),
		.tag       ('{idx: OIDX_W'(rd_idx_s1), sc: city_rd_s1.sc, best: best_rd_s1}),
		.res_valid (res_valid),
		.res_tag   (res_tag),
		.wire_cost (unit_wire),
		.busy      (unit_busy)
	);

	// New best connection of the swept city.
	always_comb begin
		if (init_q)
			cand = '{cost: EDGE_W'(res_tag.sc), parent: '0, station: 1'b1};
		else if (unit_wire < res_tag.best.cost)
			cand = '{cost: unit_wire, parent: OIDX_W'(pick_idx_q), station: 1'b0};
		else
			cand = res_tag.best;
	end

	// Control registers, sweep bookkeeping and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			n_q     <= '0;
			iss_q   <= '0;
			step_q  <= '0;
			init_q  <= 1'b0;
			found_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			conn_q  <= '0;
			total_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) iss_q <= iss_q + 1'b1;

			// The result register fills on an emit and empties when taken.
			if (state_q == ST_EMIT && can_out) out_v_q <= 1'b1;
			else if (link_ready) out_v_q <= 1'b0;

			if (accept) begin
				if (room) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
				if (city.last_city) begin
					n_q     <= room ? cnt_q + 1'b1 : cnt_q;
					init_q  <= 1'b1;
					iss_q   <= '0;
					step_q  <= '0;
					found_q <= 1'b0;
				end
			end

			// Running minimum over the open cities.
			if (res_valid && res_open && (!found_q || cand.cost < min_q.cost))
				found_q <= 1'b1;

			if (state_q == ST_EMIT && can_out) begin
				step_q  <= step_q + 1'b1;
				if (last_step) begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					total_q <= '0;
					conn_q  <= '0;
				end else begin
					conn_q[min_idx_q] <= 1'b1;
					total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
				end
			end

			if (state_q == ST_PICK_LAT) begin
				init_q  <= 1'b0;
				iss_q   <= '0;
				found_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (res_valid && res_open && (!found_q || cand.cost < min_q.cost)) begin
			min_q     <= cand;
			min_idx_q <= res_idx;
		end
		if (state_q == ST_EMIT && can_out) begin
			out_q.is_station    <= min_q.station;
			out_q.parent_city   <= min_q.station ? '0 : min_q.parent;
			out_q.city_index    <= OIDX_W'(min_idx_q);
			out_q.edge_cost     <= min_q.cost;
			out_q.running_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
			out_q.last_result   <= last_step;
			out_q.overflow      <= ovf_q;
			pick_idx_q          <= min_idx_q;
		end
		if (state_q == ST_PICK_LAT) pick_q <= city_rd_s1;
	end

	assign link_valid = out_v_q;
	assign link       = out_q;

	// The sweep never addresses past the loaded set.
	a_issue_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> iss_q < n_q)
		else $error("sweep index beyond loaded cities");

	// A full store turns an accepted item into an overflow.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !room && !city.last_city) |=> ovf_q)
		else $error("dropped item not flagged");

	// Connected cities never outnumber the loaded set.
	a_conn_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(conn_q) <= n_q)
		else $error("too many connected cities");

	// The running total always covers the edge just emitted.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> out_q.running_total >= TOTAL_W'(out_q.edge_cost))
		else $error("running total below edge cost");

	// An emit only follows a sweep that found an open city.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> found_q)
		else $error("emit without a picked city");

endmodule
